// ===== hdl/dmm_pkg.sv =====
// Shared types and codes for the dense matrix multiply block.
`default_nettype none

package dmm_pkg;

  localparam int CFG_W = 7;
  localparam int REG_IDX_W = 2;

  // Request commands
  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_COLS  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] element_value;
  } request_t;

  typedef struct packed {
    logic signed [47:0] product_value;
    logic [4:0]         product_col;
    logic               row_done;
  } result_t;

  // One multiply-accumulate step handed from controller to datapath
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       zero;
    logic       done;
    logic [5:0] row;
    logic [5:0] k;
    logic [4:0] col;
  } issue_t;

  typedef struct packed {
    logic advance;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/dmm_ctrl.sv =====
// Controller: configuration registers and the row/column/inner-index sequencer.
`default_nettype none

module dmm_ctrl #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 32,
  parameter int MAX_COLS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dmm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmm_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           request_valid,
  input  wire dmm_pkg::request_t              request,
  input  wire dmm_pkg::status_t               status,
  output logic                                request_stall,
  output dmm_pkg::issue_t                     issue
);
  import dmm_pkg::*;

  localparam int COL_CAP = (MAX_COLS < 32) ? MAX_COLS : 32;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state;
  logic [6:0] row_count;
  logic [5:0] inner_dim;
  logic [5:0] out_cols;
  logic [5:0] row;
  logic [5:0] k;
  logic [4:0] c;

  logic [5:0] kdim;
  logic [5:0] ncols;
  logic       k_end;
  logic       c_end;
  logic       accept;
  logic       start;

  always_comb begin
    kdim  = (inner_dim > MAX_INNER) ? 6'(MAX_INNER) : inner_dim;
    ncols = (out_cols > COL_CAP) ? 6'(COL_CAP) : out_cols;
    k_end = (kdim == 6'd0) || (k == kdim - 6'd1);
    c_end = ({1'b0, c} == ncols - 6'd1);
    request_stall = (state == ST_RUN);
    accept = request_valid && !request_stall;
    start  = accept && (request.command == CMD_COMPUTE) &&
             ({1'b0, request.row_index} < row_count) &&
             (request.row_index < MAX_ROWS) && (ncols != 6'd0);

    issue.valid = (state == ST_RUN);
    issue.first = (k == 6'd0);
    issue.last  = k_end;
    issue.zero  = (kdim == 6'd0);
    issue.done  = k_end && c_end;
    issue.row   = row;
    issue.k     = k;
    issue.col   = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 7'd64;
      inner_dim <= 6'd32;
      out_cols  <= 6'd32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data[5:0];
        REG_OUT_COLS:  out_cols  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (status.advance && k_end && c_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Counters and row latch carry payload only
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (start) begin
        row <= request.row_index;
        k   <= 6'd0;
        c   <= 5'd0;
      end
    end else if (status.advance) begin
      if (k_end) begin
        k <= 6'd0;
        c <= c + 5'd1;
      end else begin
        k <= k + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dmm_datapath.sv =====
// Datapath: A and B stores, multiply-accumulate pipeline and result register.
`default_nettype none

module dmm_datapath #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 32,
  parameter int MAX_COLS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire dmm_pkg::request_t  request,
  input  wire dmm_pkg::issue_t    issue,
  output dmm_pkg::status_t        status,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output dmm_pkg::result_t        result
);
  import dmm_pkg::*;

  localparam int LDEPTH = MAX_ROWS * MAX_INNER;
  localparam int RDEPTH = MAX_INNER * MAX_COLS;
  localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RAW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  logic [15:0] left_mem  [LDEPTH];
  logic [15:0] right_mem [RDEPTH];

  logic           advance;
  logic           wr_a;
  logic           wr_b;
  logic [LAW-1:0] wa_addr;
  logic [RAW-1:0] wb_addr;
  logic [LAW-1:0] ra_addr;
  logic [RAW-1:0] rb_addr;

  logic signed [15:0] a_rd;
  logic signed [15:0] b_rd;
  issue_t             s1;
  logic signed [31:0] prod;
  issue_t             s2;
  logic signed [47:0] acc;
  logic signed [47:0] acc_next;

  always_comb begin
    advance = !result_valid || !result_stall;
    status.advance = advance;

    wr_a = accept && (request.command == CMD_WRITE_A) &&
           (request.row_index < MAX_ROWS) && (request.col_index < MAX_INNER);
    wr_b = accept && (request.command == CMD_WRITE_B) &&
           (request.row_index < MAX_INNER) && (request.col_index < MAX_COLS);
    wa_addr = LAW'(request.row_index) * LAW'(MAX_INNER) + LAW'(request.col_index);
    wb_addr = RAW'(request.row_index) * RAW'(MAX_COLS) + RAW'(request.col_index);
    ra_addr = LAW'(issue.row) * LAW'(MAX_INNER) + LAW'(issue.k);
    rb_addr = RAW'(issue.k) * RAW'(MAX_COLS) + RAW'(issue.col);

    acc_next = (s2.first ? 48'sd0 : acc) + {{16{prod[31]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      left_mem[wa_addr] <= request.element_value;
    end
    if (advance) begin
      a_rd <= left_mem[ra_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      right_mem[wb_addr] <= request.element_value;
    end
    if (advance) begin
      b_rd <= right_mem[rb_addr];
    end
  end

  // Valid bits of the pipeline reset; the payload only moves on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid     <= 1'b0;
      s2.valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1.valid     <= issue.valid;
      s2.valid     <= s1.valid;
      result_valid <= s2.valid && s2.last;
    end

    if (advance) begin
      s1.first <= issue.first;
      s1.last  <= issue.last;
      s1.zero  <= issue.zero;
      s1.done  <= issue.done;
      s1.row   <= issue.row;
      s1.k     <= issue.k;
      s1.col   <= issue.col;

      s2.first <= s1.first;
      s2.last  <= s1.last;
      s2.zero  <= s1.zero;
      s2.done  <= s1.done;
      s2.row   <= s1.row;
      s2.k     <= s1.k;
      s2.col   <= s1.col;
      // An empty inner dimension sums nothing
      prod <= s1.zero ? 32'sd0 : a_rd * b_rd;

      if (s2.valid) begin
        acc <= acc_next;
        if (s2.last) begin
          result.product_value <= acc_next;
          result.product_col   <= s2.col;
          result.row_done      <= s2.done;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dense_matrix_multiply.sv =====
// Top level of the dense matrix multiply block: controller plus datapath.
//
//   channel   direction  handshake                payload
//   request   in         request_valid/_stall     request_t (command, indexes, element)
//   result    out        result_valid/_stall      result_t (sum, column, row_done)
//   config    in         cfg_write                cfg_index, cfg_data
//
// An A or B write leaves the block ready for the next request.
// A row compute issues out_cols * max(inner_dim, 1) steps, both clamped to the store
// limits, one per cycle through the single multiply-accumulate unit while no result stalls.
// Each column result passes the store-read, product and result registers after its last step is issued.
// A stalled result freezes the whole pipeline until it is taken.
// rst is synchronous; the stores hold no reset value and must be written before use.
`default_nettype none

module dense_matrix_multiply #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 32,
  parameter int MAX_COLS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dmm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmm_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           request_valid,
  output logic                                request_stall,
  input  wire dmm_pkg::request_t              request,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output dmm_pkg::result_t                    result
);
  import dmm_pkg::*;

  issue_t  issue;
  status_t status;
  logic    accept;

  assign accept = request_valid && !request_stall;

  dmm_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_valid (request_valid),
    .request       (request),
    .status        (status),
    .request_stall (request_stall),
    .issue         (issue)
  );

  dmm_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .request      (request),
    .issue        (issue),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== hdl/dmm_checker.sv =====
// Port-level checks for the dense matrix multiply block, bound to the top level.
`default_nettype none

module dmm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           request_valid,
  input wire logic                           request_stall,
  input wire dmm_pkg::request_t              request,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire dmm_pkg::result_t               result
);
  import dmm_pkg::*;

  // Held result must not change
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset leaves the block idle with nothing to deliver
  assert property (@(posedge clk) rst |=> !result_valid && !request_stall)
    else $error("block not idle after reset");

  // Store writes never start a compute
  assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall &&
    (request.command == CMD_WRITE_A || request.command == CMD_WRITE_B)
    |=> !request_stall)
    else $error("stall raised after a store write");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);

`default_nettype wire

// ===== tb/tb_dense_matrix_multiply.sv =====
// Self-checking testbench for the dense matrix multiply block: loads, row computes, shapes.
module tb_dense_matrix_multiply;
  import dmm_pkg::*;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_INNER   = 32;
  localparam int MAX_COLS    = 32;
  localparam int SETTLE      = 20;
  localparam int QUIET_LIMIT = 4000;

  localparam logic [1:0]           CMD_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Expected row products, worked out from the requests the block accepts.
  class product_board;
    logic signed [15:0] left_q [MAX_ROWS*MAX_INNER];
    logic signed [15:0] right_q [MAX_INNER*MAX_COLS];
    logic [6:0] row_count = 7'd64;
    logic [5:0] inner_dim = 6'd32;
    logic [5:0] out_cols = 6'd32;
    result_t expected_q[$];
    int mismatches = 0;

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ROW_COUNT: row_count = data;
        REG_INNER_DIM: inner_dim = data[5:0];
        REG_OUT_COLS: out_cols = data[5:0];
        default: ;
      endcase
    endfunction

    function void note_request(request_t req);
      int kdim;
      int ncols;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [31:0] prod;
      logic [47:0] acc;
      result_t want;
      case (req.command)
        CMD_WRITE_A: left_q[{req.row_index, req.col_index}] = req.element_value;
        CMD_WRITE_B: begin
          if (req.row_index < MAX_INNER)
            right_q[{req.row_index[4:0], req.col_index}] = req.element_value;
        end
        CMD_COMPUTE: begin
          if (req.row_index < row_count) begin
            kdim = (inner_dim > MAX_INNER) ? MAX_INNER : inner_dim;
            ncols = (out_cols > MAX_COLS) ? MAX_COLS : out_cols;
            for (int c = 0; c < ncols; c++) begin
              acc = '0;
              for (int k = 0; k < kdim; k++) begin
                a = left_q[{req.row_index, 5'(k)}];
                b = right_q[{5'(k), 5'(c)}];
                prod = a * b;
                acc = acc + {{16{prod[31]}}, prod};
              end
              want.product_value = acc;
              want.product_col = 5'(c);
              want.row_done = (c == ncols - 1);
              expected_q.push_back(want);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_product(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.product_value !== want.product_value) begin
        $display("%0t: product_value expected %h got %h", $time,
                 want.product_value, got.product_value);
        mismatches++;
      end
      if (got.product_col !== want.product_col) begin
        $display("%0t: product_col expected %0d got %0d", $time,
                 want.product_col, got.product_col);
        mismatches++;
      end
      if (got.row_done !== want.row_done) begin
        $display("%0t: row_done expected %b got %b", $time, want.row_done, got.row_done);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic request_valid = 1'b0;
  logic request_stall;
  request_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  logic steady = 1'b0;
  int quiet_cycles = 0;
  // rows below this are loaded far enough for the present shape
  int safe_rows = 1;
  product_board board = new;

  dense_matrix_multiply DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  // Take results and stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        board.check_product(result);
      result_stall <= !steady && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if ((request_valid && !request_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold the request until the block takes it; valid stays high on return.
  task automatic send_request(request_t req);
    request <= req;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    board.note_request(req);
  endtask

  task automatic maybe_idle();
    while (!steady && $urandom_range(99) < 14) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain();
    request_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_shape(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                           logic [CFG_W-1:0] cols);
    logic [REG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] val [4];
    idx = '{REG_ROW_COUNT, REG_INNER_DIM, REG_OUT_COLS, REG_UNUSED};
    val = '{rows, inner, cols, CFG_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      board.set_register(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_element();
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t req;
    int pick;
    req.row_index = 6'($urandom);
    req.col_index = 5'($urandom);
    req.element_value = random_element();
    pick = $urandom_range(99);
    if (pick < 35) begin
      req.command = CMD_WRITE_A;
    end else if (pick < 65) begin
      req.command = CMD_WRITE_B;
      // mostly in range; the rest may land beyond the inner dimension and is then ignored
      if ($urandom_range(4) != 0) req.row_index[5] = 1'b0;
    end else if (pick < 95) begin
      req.command = CMD_COMPUTE;
      // stay on loaded rows, or land at or past row_count where the request drops
      if (int'(board.row_count) < MAX_ROWS && $urandom_range(4) == 0)
        req.row_index = 6'($urandom_range(MAX_ROWS - 1, int'(board.row_count)));
      else
        req.row_index = 6'($urandom_range(safe_rows - 1));
    end else begin
      req.command = CMD_UNUSED;
    end
    return req;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      maybe_idle();
      send_request(random_request());
    end
  endtask

  initial begin
    request_t fill;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Load what the shapes below read: row 0 of A and column 0 of B in full,
    // rows 0-2 of A and a 4x4 corner of B over the first four inner indexes.
    for (int k = 0; k < MAX_INNER; k++) begin
      fill = request_t'{CMD_WRITE_A, 6'd0, 5'(k), random_element()};
      if (k >= 4) fill.element_value = 16'sh8000;
      maybe_idle();
      send_request(fill);
    end
    for (int r = 1; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        maybe_idle();
        send_request(request_t'{CMD_WRITE_A, 6'(r), 5'(k), random_element()});
      end
    end
    for (int k = 0; k < MAX_INNER; k++) begin
      fill = request_t'{CMD_WRITE_B, 6'(k), 5'd0, random_element()};
      if (k >= 4) fill.element_value = 16'sh8000;
      maybe_idle();
      send_request(fill);
    end
    for (int k = 0; k < 4; k++) begin
      for (int c = 1; c < 4; c++) begin
        maybe_idle();
        send_request(request_t'{CMD_WRITE_B, 6'(k), 5'(c), random_element()});
      end
    end

    // B writes past the inner dimension and an unknown command drop
    send_request(request_t'{CMD_WRITE_B, 6'd32, 5'd0, 16'sh7FFF});
    send_request(request_t'{CMD_WRITE_B, 6'd35, 5'd3, 16'sh8000});
    send_request(request_t'{CMD_UNUSED, 6'h3F, 5'h1F, 16'shFFFF});
    drain();

    // inner_dim clamps to the store width; only row 0 is loaded that far
    safe_rows = 1;
    set_shape(7'd3, 7'h3F, 7'd1);
    send_request(request_t'{CMD_COMPUTE, 6'd0, 5'd0, 16'sh0000});
    send_request(request_t'{CMD_COMPUTE, 6'd3, 5'h1F, 16'sh7FFF});
    send_random(6);
    drain();

    safe_rows = 3;
    set_shape(7'd3, 7'd4, 7'd4);
    send_random(6);
    drain();

    // no inner terms: every column sums to zero and out_cols clamps to 32
    safe_rows = MAX_ROWS;
    set_shape(7'h7F, 7'd0, 7'h3F);
    send_request(request_t'{CMD_COMPUTE, 6'd63, 5'd0, 16'sh0000});
    send_random(4);
    drain();

    // no row or no column is in use: every compute is dropped
    safe_rows = 3;
    set_shape(7'd0, 7'd4, 7'd4);
    send_random(5);
    drain();
    set_shape(7'd3, 7'd2, 7'd0);
    send_random(4);
    drain();

    safe_rows = 1;
    set_shape(7'd1, 7'd1, 7'd1);
    send_random(5);
    drain();

    steady <= 1'b1;
    safe_rows = 3;
    set_shape(7'd3, 7'd3, 7'd4);
    send_random(16);
    drain();
    steady <= 1'b0;

    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
